>>> rtl/bae_pkg.sv
package bae_pkg;

  localparam int BOUND_W    = 32;
  localparam int PROB_W     = 16;
  localparam int PROD_W     = BOUND_W + PROB_W;
  localparam int COUNT_W    = 24;
  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int STEP_W     = 3;
  localparam int MAX_SHIFTS = 4;

  localparam int PROB_BITS_DEF = 16;

  localparam logic [COUNT_W-1:0] CAP_RESET  = 24'd4096;
  localparam logic [BOUND_W-1:0] LOW_RESET  = 32'h0000_0000;
  localparam logic [BOUND_W-1:0] HIGH_RESET = 32'hffff_ffff;
  localparam logic [BYTE_W-1:0]  ENC_FILL   = 8'hff;
  localparam logic [BYTE_W-1:0]  FLUSH_FILL = 8'h80;

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_CLAMP,
    ST_SHIFT,
    ST_FLUSH,
    ST_LEN
  } bae_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic mul;
    logic sub;
    logic clamp;
    logic shift_enc;
    logic shift_fin;
    logic emit_byte;
    logic emit_len;
    logic last;
  } bae_cmd_t;

  typedef struct packed {
    logic top_eq;
    logic next_top_eq;
    logic room;
    logic room_next;
    logic slot_free;
  } bae_stat_t;

endpackage

>>> rtl/binary_arithmetic_encoder.sv
// channel  dir  tdata                                      tuser          tlast
// in_      in   [0] bit_value, [16:1] prob_one, rest zero  [1:0] opcode   -
// out_     out  [7:0] out_byte, [31:8] stream_length       [0] is_length  last result
// cfg_     in   cfg_wr_data = out_capacity, written when cfg_wr_en is high
//
// encode, once accepted, runs a multiply step, a subtract step and a clamp step, then up
// to four renormalization shifts, one per cycle unless a byte waits on the output register
// finish runs up to four flush steps at that rate, then emits the length result
// one item at a time; in_tready is high only while the sequencer is idle
// a full output register stalls the sequencer until out_tready takes the result
// rst_n is synchronous: bounds, byte count and capacity return to their reset values
module binary_arithmetic_encoder #(
  parameter int PROB_BITS = bae_pkg::PROB_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // bit_value, prob_one, zero pad
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte, stream_length
  output logic        out_tuser,  // is_length
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);

  bae_pkg::bae_cmd_t  cmd;
  bae_pkg::bae_stat_t stat;
  logic [bae_pkg::BYTE_W-1:0]  out_byte;
  logic [bae_pkg::COUNT_W-1:0] out_length;

  bae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_tready)
  );

  bae_dp #(
    .PROB_BITS (PROB_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_bit        (in_tdata[0]),
    .in_prob       (in_tdata[16:1]),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (out_byte),
    .out_is_length (out_tuser),
    .out_length    (out_length),
    .out_last      (out_tlast)
  );

  assign out_tdata = {out_length, out_byte};

endmodule

>>> rtl/bae_ctrl.sv
module bae_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [bae_pkg::OP_W-1:0]            in_opcode,
  input  bae_pkg::bae_stat_t                  stat,
  output bae_pkg::bae_cmd_t                   cmd,
  output logic                                in_ready
);

  localparam logic [bae_pkg::STEP_W-1:0] STEPS = bae_pkg::STEP_W'(bae_pkg::MAX_SHIFTS);

  bae_pkg::bae_state_t state_r, state_nxt;
  logic [bae_pkg::STEP_W-1:0] k_r, k_nxt;
  logic more;

  assign more = k_r < STEPS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bae_pkg::ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bae_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            bae_pkg::OP_ENCODE: state_nxt = bae_pkg::ST_MUL;
            bae_pkg::OP_FINISH: state_nxt = bae_pkg::ST_FLUSH;
            default:            state_nxt = bae_pkg::ST_IDLE;
          endcase
        end
      end
      bae_pkg::ST_MUL:   state_nxt = bae_pkg::ST_SUB;
      bae_pkg::ST_SUB:   state_nxt = bae_pkg::ST_CLAMP;
      bae_pkg::ST_CLAMP: state_nxt = bae_pkg::ST_SHIFT;
      bae_pkg::ST_SHIFT: begin
        if (!(more && stat.top_eq)) state_nxt = bae_pkg::ST_IDLE;
      end
      bae_pkg::ST_FLUSH: begin
        if (!(more && !stat.top_eq)) state_nxt = bae_pkg::ST_LEN;
      end
      bae_pkg::ST_LEN: begin
        if (stat.slot_free) state_nxt = bae_pkg::ST_IDLE;
      end
      default: state_nxt = bae_pkg::ST_IDLE;
    endcase
  end

  // commands and loop count
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    k_nxt    = k_r;
    case (state_r)
      bae_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        k_nxt    = '0;
        if (in_valid) begin
          case (in_opcode)
            bae_pkg::OP_START:  cmd.start = 1'b1;
            bae_pkg::OP_ENCODE: cmd.load  = 1'b1;
            default:            cmd.load  = 1'b0;
          endcase
        end
      end
      bae_pkg::ST_MUL:   cmd.mul   = 1'b1;
      bae_pkg::ST_SUB:   cmd.sub   = 1'b1;
      bae_pkg::ST_CLAMP: cmd.clamp = 1'b1;
      bae_pkg::ST_SHIFT: begin
        if (more && stat.top_eq) begin
          if (!stat.room) begin
            cmd.shift_enc = 1'b1;
            k_nxt         = k_r + 1'b1;
          end else if (stat.slot_free) begin
            cmd.shift_enc = 1'b1;
            cmd.emit_byte = 1'b1;
            // last unless the following step emits too
            cmd.last      = !((k_r < STEPS - 1'b1) && stat.next_top_eq && stat.room_next);
            k_nxt         = k_r + 1'b1;
          end
        end
      end
      bae_pkg::ST_FLUSH: begin
        if (more && !stat.top_eq) begin
          if (!stat.room) begin
            cmd.shift_fin = 1'b1;
            k_nxt         = k_r + 1'b1;
          end else if (stat.slot_free) begin
            cmd.shift_fin = 1'b1;
            cmd.emit_byte = 1'b1;
            k_nxt         = k_r + 1'b1;
          end
        end
      end
      bae_pkg::ST_LEN: begin
        if (stat.slot_free) begin
          cmd.emit_len = 1'b1;
          cmd.last     = 1'b1;
        end
      end
      default: k_nxt = '0;
    endcase
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= STEPS)
    else $error("shift step count past limit");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_byte || cmd.emit_len) |-> stat.slot_free)
    else $error("result written into a full output register");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_byte |-> stat.room)
    else $error("byte emitted past capacity");

  a_no_shift_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r == STEPS) |-> !(cmd.shift_enc || cmd.shift_fin))
    else $error("more than four shifts in one transaction");

endmodule

>>> rtl/bae_dp.sv
module bae_dp #(
  parameter int PROB_BITS = bae_pkg::PROB_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bae_pkg::bae_cmd_t                 cmd,
  output bae_pkg::bae_stat_t                stat,
  input  logic                              in_bit,
  input  logic [bae_pkg::PROB_W-1:0]        in_prob,
  input  logic                              cfg_wr_en,
  input  logic [bae_pkg::COUNT_W-1:0]       cfg_wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bae_pkg::BYTE_W-1:0]        out_byte,
  output logic                              out_is_length,
  output logic [bae_pkg::COUNT_W-1:0]       out_length,
  output logic                              out_last
);

  logic [bae_pkg::BOUND_W-1:0] low_r, high_r, split_r;
  logic [bae_pkg::COUNT_W-1:0] bytes_r, cap_r;
  logic                        bit_r;
  logic [bae_pkg::PROB_W-1:0]  prob_r;
  logic [bae_pkg::PROD_W-1:0]  prod_r;

  logic                        valid_r;
  logic [bae_pkg::BYTE_W-1:0]  byte_r;
  logic                        is_len_r;
  logic [bae_pkg::COUNT_W-1:0] len_r;
  logic                        last_r;

  logic [bae_pkg::BOUND_W-1:0] range, prod_sat, split_lo, split_cl, high_m1;
  logic [bae_pkg::PROD_W-1:0]  prod_sh;
  logic [bae_pkg::COUNT_W:0]   bytes_inc;

  assign range    = high_r - low_r;
  assign prod_sh  = prod_r >> PROB_BITS;
  // a product above the range can only come from a short probability format
  assign prod_sat = (prod_sh > {{bae_pkg::PROB_W{1'b0}}, range})
                    ? range : prod_sh[bae_pkg::BOUND_W-1:0];
  assign high_m1  = high_r - 1'b1;
  assign split_lo = (split_r < low_r) ? low_r : split_r;
  assign split_cl = (split_lo > high_m1) ? high_m1 : split_lo;
  assign bytes_inc = {1'b0, bytes_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= bae_pkg::LOW_RESET;
      high_r  <= bae_pkg::HIGH_RESET;
      bytes_r <= '0;
      cap_r   <= bae_pkg::CAP_RESET;
      valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (cmd.start) begin
        low_r   <= bae_pkg::LOW_RESET;
        high_r  <= bae_pkg::HIGH_RESET;
        bytes_r <= '0;
      end
      if (cmd.clamp) begin
        if (bit_r) low_r  <= split_cl + 1'b1;
        else       high_r <= split_cl;
      end
      if (cmd.shift_enc) begin
        low_r  <= {low_r[bae_pkg::BOUND_W-bae_pkg::BYTE_W-1:0], {bae_pkg::BYTE_W{1'b0}}};
        high_r <= {high_r[bae_pkg::BOUND_W-bae_pkg::BYTE_W-1:0], bae_pkg::ENC_FILL};
      end
      if (cmd.shift_fin) begin
        low_r  <= {low_r[bae_pkg::BOUND_W-bae_pkg::BYTE_W-1:0], bae_pkg::FLUSH_FILL};
        high_r <= {high_r[bae_pkg::BOUND_W-bae_pkg::BYTE_W-1:0], bae_pkg::FLUSH_FILL};
      end
      if (cmd.emit_byte) bytes_r <= bytes_inc[bae_pkg::COUNT_W-1:0];
      if (cmd.emit_byte || cmd.emit_len) valid_r <= 1'b1;
      else if (out_ready)                valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bit_r  <= in_bit;
      prob_r <= in_prob;
    end
    if (cmd.mul) prod_r  <= {{bae_pkg::PROB_W{1'b0}}, range} *
                            {{bae_pkg::BOUND_W{1'b0}}, prob_r};
    if (cmd.sub) split_r <= high_r - prod_sat;
    if (cmd.emit_byte) begin
      byte_r   <= low_r[bae_pkg::BOUND_W-1 -: bae_pkg::BYTE_W];
      is_len_r <= 1'b0;
      len_r    <= '0;
      last_r   <= cmd.last;
    end else if (cmd.emit_len) begin
      byte_r   <= '0;
      is_len_r <= 1'b1;
      len_r    <= bytes_r;
      last_r   <= cmd.last;
    end
  end

  assign stat.top_eq      = low_r[31:24] == high_r[31:24];
  assign stat.next_top_eq = low_r[23:16] == high_r[23:16];
  assign stat.room        = bytes_r < cap_r;
  assign stat.room_next   = bytes_inc < {1'b0, cap_r};
  assign stat.slot_free   = !valid_r || out_ready;

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_is_length = is_len_r;
  assign out_length    = len_r;
  assign out_last      = last_r;

  a_len_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_len |=> (valid_r && is_len_r && last_r))
    else $error("length result not registered");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.emit_byte && !cmd.start) |=> $stable(bytes_r))
    else $error("byte count moved without a stored byte");

  a_start_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (low_r == bae_pkg::LOW_RESET && high_r == bae_pkg::HIGH_RESET))
    else $error("start did not reset the bounds");

endmodule
